// ===== src/nbcp_pkg.sv =====
// Package for the nine-bit continuation packer.
// Holds the word structs, the command struct, kind codes, reset-mode bits and unit constants.
// No dependencies.
package nbcp_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned UNIT_BITS = 9;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    // Bits of reset_mode.
    localparam int unsigned MODE_READER = 0;
    localparam int unsigned MODE_WRITER = 1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
        logic [1:0] reset_mode;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        more_follows;
        logic [10:0] stream_size;
        logic        overflow;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic finish;
    } t_cmd;

endpackage

// ===== src/nine_bit_continuation_packer.sv =====
// Top level of the nine-bit continuation packer.
// Joins the controller (nbcp_ctrl) and the datapath (nbcp_dp); uses nbcp_pkg.
//
// Channel   Direction  Handshake           Word type
// -------   ---------  ------------------  --------------------
// item      in         start, busy         nbcp_pkg::t_in_word
// result    out        o_done strobe       nbcp_pkg::t_out_word
//
// In the accept cycle of each word both store bytes under the unit are read
// (and the upper byte of a written unit is stored); in its finish state the
// lower byte is merged and written and the result registered. The single write
// port of the byte store sets this split. The result shows for one cycle with
// o_done high, and start may be taken in that same cycle. Reset is synchronous
// and clears the positions and the used size; the store is not swept, because
// no bit at or beyond the write position is ever read. The receiver cannot
// stall; busy is the only back pressure on the sender.
module nine_bit_continuation_packer #(
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  nbcp_pkg::t_in_word  i_item,
    output logic                o_done,
    output nbcp_pkg::t_out_word o_result
);

    nbcp_pkg::t_cmd cmd;

    // The sequencer puts a finish state after each accepted word.
    nbcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    // Store, positions and result register.
    nbcp_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_result (o_result)
    );

endmodule

// ===== src/nbcp_ctrl.sv =====
// Controller of the nine-bit continuation packer.
// Two-state sequencer that issues accept and finish commands.
// Depends on nbcp_pkg.
module nbcp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output nbcp_pkg::t_cmd o_cmd,
    output logic          o_done
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_FINISH = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FINISH);
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cmd.accept = start && (r_state == S_IDLE);
    assign o_cmd.finish = (r_state == S_FINISH);
    assign o_done       = r_done;

endmodule

// ===== src/nbcp_dp.sv =====
// Datapath of the nine-bit continuation packer.
// Holds the byte store, the bit positions, the used size and the result register.
// Depends on nbcp_pkg.
module nbcp_dp #(
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nbcp_pkg::t_in_word  i_item,
    input  nbcp_pkg::t_cmd      i_cmd,
    output nbcp_pkg::t_out_word o_result
);

    localparam int unsigned STORE_BITS = STORE_BYTES * nbcp_pkg::BYTE_BITS;
    localparam int unsigned PW = $clog2(STORE_BITS + 1);
    localparam int unsigned AW = $clog2(STORE_BYTES);
    localparam int unsigned UW = $clog2(STORE_BYTES + 1);
    localparam int unsigned SW = (UW > 11) ? UW : 11;

    logic [7:0] mem [STORE_BYTES];

    logic [PW-1:0] r_wpos;
    logic [PW-1:0] r_rpos;
    logic [UW-1:0] r_used;

    logic [1:0]    r_kind;
    logic [7:0]    r_data;
    logic [1:0]    r_mode;
    logic          r_fit;
    logic [2:0]    r_off;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_lo;
    logic [7:0]    r_hi;
    nbcp_pkg::t_out_word r_res;

    logic [PW-1:0] sel_pos;
    logic [2:0]    off;
    logic [AW-1:0] idx;
    logic [AW-1:0] idx_hi;
    logic [PW:0]   w_end;
    logic [PW:0]   r_end;
    logic          fit;
    logic [8:0]    unit_in;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    low_mask;
    logic [8:0]    unit_out;
    logic [PW-1:0] nxt_wpos;
    logic [PW-1:0] nxt_bytes;
    logic [UW-1:0] nxt_used;
    logic [SW-1:0] size_ext;

    // The address is chosen from the incoming word so the two store bytes
    // come back registered at the accept edge.
    assign sel_pos = (i_item.kind == nbcp_pkg::KIND_READ) ? r_rpos : r_wpos;
    assign off     = sel_pos[2:0];
    assign idx     = AW'(sel_pos >> 3);
    assign idx_hi  = idx + AW'(1);

    assign w_end = {1'b0, r_wpos} + (PW + 1)'(nbcp_pkg::UNIT_BITS);
    assign r_end = {1'b0, r_rpos} + (PW + 1)'(nbcp_pkg::UNIT_BITS);
    assign fit   = (i_item.kind == nbcp_pkg::KIND_READ)
                 ? (r_end <= {1'b0, r_wpos})
                 : (w_end <= (PW + 1)'(STORE_BITS));

    assign unit_in  = {~i_item.last, i_item.data_byte};
    assign low_mask = (8'd1 << r_off) - 8'd1;

    // Upper byte of a written unit goes in at accept; the lower byte is merged
    // with the bits below the write position in the finish cycle.
    always_comb begin
        we    = 1'b0;
        waddr = idx_hi;
        wdata = 8'(unit_in >> (4'd8 - {1'b0, off}));
        if (i_cmd.accept && (i_item.kind == nbcp_pkg::KIND_WRITE) && fit) begin
            we = 1'b1;
        end
        if (i_cmd.finish) begin
            waddr = r_idx;
            wdata = (r_lo & low_mask) | 8'(r_data << r_off);
            we    = (r_kind == nbcp_pkg::KIND_WRITE) && r_fit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_lo <= mem[idx];
        r_hi <= mem[idx_hi];
    end

    assign unit_out  = 9'({r_hi, r_lo} >> r_off);
    assign nxt_wpos  = r_wpos + PW'(nbcp_pkg::UNIT_BITS);
    assign nxt_bytes = (nxt_wpos >> 3) + PW'(1);
    assign nxt_used  = (nxt_bytes > PW'(STORE_BYTES)) ? UW'(STORE_BYTES) : UW'(nxt_bytes);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_item.kind;
            r_data <= i_item.data_byte;
            r_mode <= i_item.reset_mode;
            r_fit  <= fit;
            r_off  <= off;
            r_idx  <= idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_rpos <= '0;
            r_used <= '0;
        end else if (i_cmd.finish) begin
            case (r_kind)
                nbcp_pkg::KIND_WRITE: begin
                    if (r_fit) begin
                        r_wpos <= nxt_wpos;
                        r_used <= nxt_used;
                    end
                end
                nbcp_pkg::KIND_READ: begin
                    if (r_fit) begin
                        r_rpos <= r_rpos + PW'(nbcp_pkg::UNIT_BITS);
                    end
                end
                nbcp_pkg::KIND_RESET: begin
                    if (r_mode[nbcp_pkg::MODE_READER]) begin
                        r_rpos <= '0;
                    end
                    if (r_mode[nbcp_pkg::MODE_WRITER]) begin
                        r_wpos <= '0;
                        r_used <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Size after the item, as it will stand once the finish edge has passed.
    always_comb begin
        size_ext = SW'(r_used);
        if ((r_kind == nbcp_pkg::KIND_WRITE) && r_fit) begin
            size_ext = SW'(nxt_used);
        end else if ((r_kind == nbcp_pkg::KIND_RESET) && r_mode[nbcp_pkg::MODE_WRITER]) begin
            size_ext = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res.stream_size  <= size_ext[10:0];
            r_res.read_byte    <= '0;
            r_res.more_follows <= 1'b0;
            r_res.overflow     <= 1'b0;
            case (r_kind)
                nbcp_pkg::KIND_WRITE: begin
                    r_res.overflow <= ~r_fit;
                end
                nbcp_pkg::KIND_READ: begin
                    r_res.overflow <= ~r_fit;
                    if (r_fit) begin
                        r_res.read_byte    <= unit_out[7:0];
                        r_res.more_follows <= unit_out[8];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = r_res;

endmodule

// ===== tb/sv/tb_nine_bit_continuation_packer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nine_bit_continuation_packer: a stream tracker class predicts
// each result word from the accepted item words. Depends on nbcp_pkg and the packer RTL.
module tb_nine_bit_continuation_packer;

    localparam int unsigned STORE_BYTES = 1024;
    localparam int unsigned ITEM_TARGET = 1950;
    // Whole 9-bit units that fit into the store before a write is refused.
    localparam int unsigned UNITS_IN_STORE =
        (STORE_BYTES * nbcp_pkg::BYTE_BITS) / nbcp_pkg::UNIT_BITS;
    // The one kind code that the packer does not act on.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Tracks the bit stream the packer should hold and the result words still owed.
    class t_stream_tracker;
        bit [7:0]            byte_image [STORE_BYTES];
        int unsigned         wr_bit;
        int unsigned         rd_bit;
        int unsigned         used;
        nbcp_pkg::t_out_word owed_results [$];
        int unsigned         mismatches;
        int unsigned         results_seen;
        int unsigned         overflows_seen;
        int unsigned         kind_count [4];

        function new();
            foreach (byte_image[k]) byte_image[k] = 8'h00;
            wr_bit = 0;
            rd_bit = 0;
            used   = 0;
        endfunction

        // Works out the result word that an accepted item word must produce.
        function void take_item(nbcp_pkg::t_in_word w);
            nbcp_pkg::t_out_word r;
            logic [8:0]          unit;
            int unsigned         pos;
            int unsigned         i;
            r = '0;
            unit = '0;
            kind_count[w.kind]++;
            case (w.kind)
                nbcp_pkg::KIND_WRITE: begin
                    if (wr_bit + nbcp_pkg::UNIT_BITS > STORE_BYTES * nbcp_pkg::BYTE_BITS) begin
                        r.overflow = 1'b1;
                    end else begin
                        // The continuation bit sits above the data byte and is set
                        // unless this byte closes its message.
                        unit = {~w.last, w.data_byte};
                        for (i = 0; i < nbcp_pkg::UNIT_BITS; i++) begin
                            pos = wr_bit + i;
                            byte_image[pos / nbcp_pkg::BYTE_BITS][pos % nbcp_pkg::BYTE_BITS]
                                = unit[i];
                        end
                        wr_bit += nbcp_pkg::UNIT_BITS;
                        used = wr_bit / nbcp_pkg::BYTE_BITS + 1;
                        if (used > STORE_BYTES) used = STORE_BYTES;
                    end
                end
                nbcp_pkg::KIND_READ: begin
                    if (rd_bit + nbcp_pkg::UNIT_BITS > wr_bit) begin
                        r.overflow = 1'b1;
                    end else begin
                        for (i = 0; i < nbcp_pkg::UNIT_BITS; i++) begin
                            pos = rd_bit + i;
                            unit[i] =
                                byte_image[pos / nbcp_pkg::BYTE_BITS][pos % nbcp_pkg::BYTE_BITS];
                        end
                        rd_bit += nbcp_pkg::UNIT_BITS;
                        r.read_byte    = unit[7:0];
                        r.more_follows = unit[8];
                    end
                end
                nbcp_pkg::KIND_RESET: begin
                    if (w.reset_mode[nbcp_pkg::MODE_READER]) rd_bit = 0;
                    if (w.reset_mode[nbcp_pkg::MODE_WRITER]) begin
                        wr_bit = 0;
                        used   = 0;
                    end
                end
                default: begin
                end
            endcase
            r.stream_size = 11'(used);
            owed_results.push_back(r);
        endfunction

        function void report_field(string field, int unsigned want, int unsigned got);
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        endfunction

        // Compares a result word with the oldest one still owed.
        function void match_result(nbcp_pkg::t_out_word got);
            nbcp_pkg::t_out_word want;
            results_seen++;
            if (got.overflow) overflows_seen++;
            if (owed_results.size() == 0) begin
                $display("%0t ns: result word %h arrived with nothing owed", $time, got);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.read_byte !== want.read_byte)
                report_field("read_byte", want.read_byte, got.read_byte);
            if (got.more_follows !== want.more_follows)
                report_field("more_follows", want.more_follows, got.more_follows);
            if (got.stream_size !== want.stream_size)
                report_field("stream_size", want.stream_size, got.stream_size);
            if (got.overflow !== want.overflow)
                report_field("overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                o_done;
    nbcp_pkg::t_in_word  i_item;
    nbcp_pkg::t_out_word o_result;

    t_stream_tracker tracker = new();

    int unsigned words_sent;
    // While set, the sender never idles between words.
    bit          steady;

    always #5 i_clk = ~i_clk;

    nine_bit_continuation_packer #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // Both handshakes are observed at the clock edge itself, so the values seen are the
    // ones the packer sees. A result is checked before the word accepted at the same edge
    // is noted, although the two can never belong to one another.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) tracker.match_result(o_result);
            if (start && !busy) tracker.take_item(i_item);
        end
    end

    // Hard stop in case the packer hangs or stops raising o_done.
    initial begin
        #2ms;
        $display("nine_bit_continuation_packer verification failed");
        $finish;
    end

    function automatic nbcp_pkg::t_in_word word_of(logic [1:0] kind, logic [7:0] data,
                                                   logic last, logic [1:0] mode);
        nbcp_pkg::t_in_word w;
        w.kind       = kind;
        w.data_byte  = data;
        w.last       = last;
        w.reset_mode = mode;
        return w;
    endfunction

    // Lowers start and puts junk on the item bus, which must be ignored, then waits.
    task automatic pause_cycles(int unsigned n);
        start  <= 1'b0;
        i_item <= nbcp_pkg::t_in_word'(13'($urandom));
        repeat (n) @(posedge i_clk);
    endtask

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(nbcp_pkg::t_in_word w);
        if (!steady && $urandom_range(99) < 8) pause_cycles($urandom_range(1, 3));
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    task automatic write_byte(logic [7:0] data, logic last);
        send_word(word_of(nbcp_pkg::KIND_WRITE, data, last, 2'($urandom)));
    endtask

    task automatic read_byte();
        send_word(word_of(nbcp_pkg::KIND_READ, 8'($urandom), 1'($urandom), 2'($urandom)));
    endtask

    task automatic rewind(logic [1:0] mode);
        send_word(word_of(nbcp_pkg::KIND_RESET, 8'($urandom), 1'($urandom), mode));
    endtask

    // Holds the sender back until every owed result word has come in. The owed words are
    // checked after waiting on the clock, so a word taken at the current edge is noted.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.owed_results.size() != 0);
    endtask

    initial begin
        int unsigned pick;
        int unsigned n;
        int unsigned j;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        words_sent = 0;
        steady     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: extreme bytes with and without the continuation bit, a read
        // that runs past the written data, the unused kind, a reset with no mode bits,
        // each rewind on its own, and a rewritten unit after the writer was rewound.
        write_byte(8'h00, 1'b0);
        write_byte(8'hFF, 1'b1);
        write_byte(8'hA5, 1'b0);
        write_byte(8'h5A, 1'b1);
        repeat (4) read_byte();
        read_byte();
        send_word(word_of(KIND_SPARE, 8'hFF, 1'b1, 2'b11));
        send_word(word_of(KIND_SPARE, 8'h00, 1'b0, 2'b00));
        rewind(2'b00);
        rewind(2'b01);
        repeat (2) read_byte();
        rewind(2'b10);
        read_byte();
        write_byte(8'h3C, 1'b0);
        write_byte(8'hC3, 1'b1);
        rewind(2'b01);
        repeat (2) read_byte();
        rewind(2'b11);
        read_byte();
        write_byte(8'h81, 1'b1);
        read_byte();

        // The sender waits here for the packer to empty out completely.
        wait_for_drain();

        // Fill the whole store without any gaps, run two writes past its end, then read
        // back from the front and from a rewound reader.
        steady = 1'b1;
        rewind(2'b11);
        for (j = 0; j < UNITS_IN_STORE + 2; j++)
            write_byte(8'($urandom), $urandom_range(7) == 0);
        repeat (20) read_byte();
        rewind(2'b01);
        repeat (5) read_byte();
        rewind(2'b11);
        steady = 1'b0;

        // Random part: mostly whole messages that are written and then read back, with
        // stray reads, rewinds and junk words mixed in.
        while (words_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                n = $urandom_range(1, 12);
                for (j = 0; j < n; j++) write_byte(8'($urandom), j == n - 1);
                if ($urandom_range(4) != 0) begin
                    n += ($urandom_range(5) == 0);
                    repeat (n) read_byte();
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) read_byte();
            end else if (pick < 92) begin
                rewind(2'($urandom));
                if ($urandom_range(19) == 0) wait_for_drain();
            end else begin
                send_word(nbcp_pkg::t_in_word'(13'($urandom)));
            end
        end

        wait_for_drain();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d words: %0d writes, %0d reads, %0d rewinds, %0d of the unused kind.",
                 words_sent, tracker.kind_count[nbcp_pkg::KIND_WRITE],
                 tracker.kind_count[nbcp_pkg::KIND_READ],
                 tracker.kind_count[nbcp_pkg::KIND_RESET], tracker.kind_count[KIND_SPARE]);
        $display("Checked %0d result words, %0d of them flagging overflow; %0d mismatches.",
                 tracker.results_seen, tracker.overflows_seen, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("nine_bit_continuation_packer verification clean");
        end else begin
            $display("nine_bit_continuation_packer verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/nbcp_pkg.sv
src/nbcp_ctrl.sv
src/nbcp_dp.sv
src/nine_bit_continuation_packer.sv
tb/sv/tb_nine_bit_continuation_packer.sv
